[src/mslbs_pkg.sv]
package mslbs_pkg;

	localparam int NUM_SLOTS    = 10;
	localparam int SLOT_CAP_MAX = 32;
	localparam int MAX_RESULTS  = 32;

	localparam int DEPTH  = NUM_SLOTS * SLOT_CAP_MAX;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int EIDX_W = (SLOT_CAP_MAX > 1) ? $clog2(SLOT_CAP_MAX) : 1;
	localparam int CNT_W  = $clog2(SLOT_CAP_MAX + 1);

	typedef enum logic [2:0] {
		ACT_CREATE = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_DROP   = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_RESIZE = 3'd4,
		ACT_COUNT  = 3'd5,
		ACT_READ   = 3'd6,
		ACT_SORTED = 3'd7
	} action_t;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_EXISTS   = 4'd1,
		ST_BADPOS   = 4'd2,
		ST_NOMEM    = 4'd3,
		ST_BADSIZE  = 4'd4,
		ST_FULL     = 4'd5,
		ST_NOLIST   = 4'd6,
		ST_EMPTY    = 4'd7,
		ST_NOTFOUND = 4'd8,
		ST_BADNEW   = 4'd9
	} status_t;

	// flat address of element i in the row of list s
	function automatic logic [AW-1:0] elem_addr(logic [SIDX_W-1:0] s, logic [EIDX_W-1:0] i);
		logic [AW-1:0] base;
		base = AW'(s) * AW'(SLOT_CAP_MAX);
		return base + AW'(i);
	endfunction

endpackage

[src/mslbs_req_if.sv]
interface mslbs_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [3:0]         slot;
	logic signed [7:0]  amount;
	logic signed [31:0] value;

	modport source (output valid, action, slot, amount, value, input ready);
	modport sink   (input valid, action, slot, amount, value, output ready);
endinterface

[src/mslbs_rsp_if.sv]
interface mslbs_rsp_if;
	logic               valid;
	logic               ready;
	logic [3:0]         status;
	logic signed [31:0] data;
	logic               last;

	modport source (output valid, status, data, last, input ready);
	modport sink   (input valid, status, data, last, output ready);
endinterface

[src/mslbs_ram.sv]
module mslbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/multi_slot_bounded_list_store_top.sv]
// Store of numbered bounded lists (positions 1..NUM_SLOTS), each in its own
// row of SLOT_CAP_MAX words in one synchronous RAM.
// req channel: one word per operation (action, slot, amount, value).
// rsp channel: status, data and last; last marks the final word of an operation.
// Every operation gives one word, except a read of a non-empty list, which gives
// one word per element (at most MAX_RESULTS).
// Timing: one operation at a time; req.ready is high while the control is idle.
// Create, append, drop, resize, count and errors: the result is registered, then
// loaded into the output register. Delete: reads and compares each element until
// the first match, then shifts each later element down by one. Read: reads and emits
// each element in turn. Sorted read: one full pass over the filled entries of the list
// per emitted element. The RAM read port (one read a cycle, registered) paces these steps.
// The output register holds a word until rsp.ready; the control stalls behind it
// and a new request is still taken while the last word waits.
// Reset clears all list descriptors; element words need no clearing since only
// entries below the fill are ever read.
module multi_slot_bounded_list_store_top (
	input logic         clk,
	input logic         arst_n,
	mslbs_req_if.sink   req,
	mslbs_rsp_if.source rsp
);

	localparam int W8 = 8;
	localparam logic signed [7:0] CAP_S  = 8'(mslbs_pkg::SLOT_CAP_MAX);
	localparam logic signed [9:0] NC_MAX = 10'(mslbs_pkg::SLOT_CAP_MAX);

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_DEL_RD, S_DEL_CHK, S_SH_RD, S_SH_WR,
		S_RD_RD, S_RD_OUT, S_SO_RD, S_SO_CHK, S_SO_OUT
	} state_t;

	typedef logic [mslbs_pkg::CNT_W-1:0]  cnt_t;
	typedef logic [mslbs_pkg::SIDX_W-1:0] sidx_t;

	state_t state_q, ret_q;

	logic  present_q [mslbs_pkg::NUM_SLOTS];
	cnt_t  cap_q     [mslbs_pkg::NUM_SLOTS];
	cnt_t  fill_q    [mslbs_pkg::NUM_SLOTS];

	sidx_t              s_q;
	logic signed [31:0] val_q;
	cnt_t               j_q, k_q, n_q, fl_q;
	logic signed [31:0] bval_q, pval_q;
	cnt_t               bidx_q, pidx_q;
	logic               bv_q;

	mslbs_pkg::status_t res_stat_q;
	logic signed [31:0] res_data_q;
	logic               res_last_q;

	logic               ov_q;
	logic [3:0]         o_stat_q;
	logic signed [31:0] o_data_q;
	logic               o_last_q;

	// request decode
	logic               acc, badpos, ld;
	sidx_t              s_in;
	mslbs_pkg::action_t act;
	cnt_t               cur_fill, cur_cap;
	logic signed [9:0]  nc;
	logic               ram_we;
	logic [mslbs_pkg::AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;
	logic signed [31:0] rv;
	logic               cand, better;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign act       = mslbs_pkg::action_t'(req.action);
	assign badpos    = (req.slot == 4'd0) || (req.slot > 4'(mslbs_pkg::NUM_SLOTS));
	assign s_in      = sidx_t'(req.slot - 4'd1);
	assign cur_fill  = badpos ? '0 : fill_q[s_in];
	assign cur_cap   = badpos ? '0 : cap_q[s_in];
	assign nc        = $signed(10'(cur_cap)) + 10'(req.amount);
	assign ld        = (state_q == S_EMIT) && (!ov_q || rsp.ready);
	assign rv        = $signed(ram_rdata);

	// sorted pass: next candidate is the smallest element after the previous one
	assign cand   = (k_q == '0) || (rv > pval_q) || (rv == pval_q && j_q > pidx_q);
	assign better = !bv_q || (rv < bval_q);

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mslbs_pkg::elem_addr(s_in, cur_fill[mslbs_pkg::EIDX_W-1:0]);
		ram_wdata = req.value;
		ram_raddr = mslbs_pkg::elem_addr(s_q, j_q[mslbs_pkg::EIDX_W-1:0]);
		if (acc && !badpos && act == mslbs_pkg::ACT_APPEND && present_q[s_in]
			&& cur_fill < cur_cap) begin
			ram_we = 1'b1;
		end
		if (state_q == S_SH_WR) begin
			ram_we    = 1'b1;
			ram_waddr = mslbs_pkg::elem_addr(s_q, j_q[mslbs_pkg::EIDX_W-1:0]);
			ram_wdata = ram_rdata;
		end
		if (state_q == S_SH_RD) begin
			ram_raddr = mslbs_pkg::elem_addr(s_q, mslbs_pkg::EIDX_W'(j_q + cnt_t'(1)));
		end
	end

	mslbs_ram #(.WIDTH(32), .DEPTH(mslbs_pkg::DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control, descriptors and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			present_q  <= '{default: 1'b0};
			cap_q      <= '{default: '0};
			fill_q     <= '{default: '0};
			s_q        <= '0;
			val_q      <= '0;
			j_q        <= '0;
			k_q        <= '0;
			n_q        <= '0;
			fl_q       <= '0;
			bval_q     <= '0;
			pval_q     <= '0;
			bidx_q     <= '0;
			pidx_q     <= '0;
			bv_q       <= 1'b0;
			res_stat_q <= mslbs_pkg::ST_OK;
			res_data_q <= '0;
			res_last_q <= 1'b0;
			ov_q       <= 1'b0;
			o_stat_q   <= '0;
			o_data_q   <= '0;
			o_last_q   <= 1'b0;
		end else begin
			// drain the output register
			if (ld) begin
				ov_q     <= 1'b1;
				o_stat_q <= res_stat_q;
				o_data_q <= res_data_q;
				o_last_q <= res_last_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						s_q        <= s_in;
						val_q      <= req.value;
						fl_q       <= cur_fill;
						j_q        <= '0;
						k_q        <= '0;
						bv_q       <= 1'b0;
						res_stat_q <= mslbs_pkg::ST_OK;
						res_data_q <= '0;
						res_last_q <= 1'b1;
						ret_q      <= S_IDLE;
						state_q    <= S_EMIT;
						if (badpos) begin
							res_stat_q <= mslbs_pkg::ST_BADPOS;
						end else if (act == mslbs_pkg::ACT_CREATE) begin
							priority if (present_q[s_in]) begin
								res_stat_q <= mslbs_pkg::ST_EXISTS;
							end else if (req.amount < 8'sd1) begin
								res_stat_q <= mslbs_pkg::ST_BADSIZE;
							end else if (req.amount > CAP_S) begin
								res_stat_q <= mslbs_pkg::ST_NOMEM;
							end else begin
								present_q[s_in] <= 1'b1;
								cap_q[s_in]     <= cnt_t'(req.amount);
								fill_q[s_in]    <= '0;
							end
						end else if (!present_q[s_in]) begin
							res_stat_q <= mslbs_pkg::ST_NOLIST;
						end else begin
							unique case (act)
								mslbs_pkg::ACT_APPEND: begin
									if (cur_fill >= cur_cap) begin
										res_stat_q <= mslbs_pkg::ST_FULL;
									end else begin
										fill_q[s_in] <= cur_fill + cnt_t'(1);
									end
								end
								mslbs_pkg::ACT_DROP: begin
									if (cur_fill == '0) begin
										res_stat_q <= mslbs_pkg::ST_EMPTY;
									end else begin
										fill_q[s_in] <= cur_fill - cnt_t'(1);
									end
								end
								mslbs_pkg::ACT_DELETE: begin
									if (cur_fill == '0) begin
										res_stat_q <= mslbs_pkg::ST_EMPTY;
									end else begin
										state_q <= S_DEL_RD;
									end
								end
								mslbs_pkg::ACT_RESIZE: begin
									priority if (nc < 10'sd1) begin
										res_stat_q <= mslbs_pkg::ST_BADNEW;
									end else if (nc > NC_MAX) begin
										res_stat_q <= mslbs_pkg::ST_NOMEM;
									end else begin
										cap_q[s_in] <= cnt_t'(nc);
										if (10'(cur_fill) > nc) begin
											fill_q[s_in] <= cnt_t'(nc);
										end
									end
								end
								mslbs_pkg::ACT_COUNT: begin
									if (cur_fill == '0) begin
										res_stat_q <= mslbs_pkg::ST_EMPTY;
									end else begin
										res_data_q <= 32'(cur_fill);
									end
								end
								mslbs_pkg::ACT_READ, mslbs_pkg::ACT_SORTED: begin
									n_q <= (W8'(cur_fill) > W8'(mslbs_pkg::MAX_RESULTS))
										? cnt_t'(mslbs_pkg::MAX_RESULTS) : cur_fill;
									if (cur_fill != '0) begin
										state_q <= (act == mslbs_pkg::ACT_READ)
											? S_RD_RD : S_SO_RD;
									end
								end
								default: ;
							endcase
						end
					end
				end
				S_EMIT: begin
					if (ld) begin
						state_q <= ret_q;
					end
				end
				// search for the first match
				S_DEL_RD: state_q <= S_DEL_CHK;
				S_DEL_CHK: begin
					if (rv == val_q) begin
						if (j_q + cnt_t'(1) < fl_q) begin
							state_q <= S_SH_RD;
						end else begin
							fill_q[s_q] <= fl_q - cnt_t'(1);
							state_q     <= S_EMIT;
						end
					end else if (j_q + cnt_t'(1) == fl_q) begin
						res_stat_q <= mslbs_pkg::ST_NOTFOUND;
						state_q    <= S_EMIT;
					end else begin
						j_q     <= j_q + cnt_t'(1);
						state_q <= S_DEL_RD;
					end
				end
				// shift later elements down by one
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					j_q <= j_q + cnt_t'(1);
					if (j_q + cnt_t'(2) < fl_q) begin
						state_q <= S_SH_RD;
					end else begin
						fill_q[s_q] <= fl_q - cnt_t'(1);
						state_q     <= S_EMIT;
					end
				end
				// plain readout
				S_RD_RD: state_q <= S_RD_OUT;
				S_RD_OUT: begin
					res_data_q <= rv;
					res_last_q <= (j_q + cnt_t'(1) == n_q);
					ret_q      <= (j_q + cnt_t'(1) == n_q) ? S_IDLE : S_RD_RD;
					j_q        <= j_q + cnt_t'(1);
					state_q    <= S_EMIT;
				end
				// sorted readout, one pass per emitted word
				S_SO_RD: state_q <= S_SO_CHK;
				S_SO_CHK: begin
					if (cand && better) begin
						bv_q   <= 1'b1;
						bval_q <= rv;
						bidx_q <= j_q;
					end
					if (j_q + cnt_t'(1) == fl_q) begin
						state_q <= S_SO_OUT;
					end else begin
						j_q     <= j_q + cnt_t'(1);
						state_q <= S_SO_RD;
					end
				end
				S_SO_OUT: begin
					res_data_q <= bval_q;
					res_last_q <= (k_q + cnt_t'(1) == n_q);
					ret_q      <= (k_q + cnt_t'(1) == n_q) ? S_IDLE : S_SO_RD;
					pval_q     <= bval_q;
					pidx_q     <= bidx_q;
					k_q        <= k_q + cnt_t'(1);
					j_q        <= '0;
					bv_q       <= 1'b0;
					state_q    <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid  = ov_q;
	assign rsp.status = o_stat_q;
	assign rsp.data   = o_data_q;
	assign rsp.last   = o_last_q;

	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && s_q < sidx_t'(mslbs_pkg::NUM_SLOTS))
		|-> (fill_q[s_q] <= cap_q[s_q]))
		else $error("fill above capacity");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SH_WR || state_q == S_IDLE))
		else $error("RAM write outside append or shift");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && res_last_q) |=> (state_q == S_IDLE))
		else $error("final word did not return control to idle");

	a_sort_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SO_OUT) |-> bv_q)
		else $error("sorted pass ended without a candidate");

endmodule
